// File: design/csp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and constants for the Catmull-Rom spline point block.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int unsigned STEP_W      = 16;
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic                      advance;
    logic                      restart;
    logic [STEP_W-1:0]         step_dt;
    logic signed [FIELD_W-1:0] ctrl_a;
    logic signed [FIELD_W-1:0] ctrl_b;
    logic signed [FIELD_W-1:0] ctrl_c;
    logic signed [FIELD_W-1:0] ctrl_d;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] point_coord;
    logic                      clipped;
  } out_item_t;

  // handshake between the queue and its neighbors
  typedef struct packed {
    logic push;
    logic full;
  } q_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic not_empty;
  } q_rd_ctl_t;

endpackage
`default_nettype wire

// File: design/csp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_front
// Accepts items, updates the running parameter t and forms the four
// polynomial coefficients, handing {t, c3, c2, c1, c0} to the queue.
// ----------------------------------------------------------------------------
module csp_front #(
  parameter int unsigned CW = 32,
  parameter int unsigned F  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire csp_pkg::in_item_t          in_item,
  input  wire logic                       q_full,
  output csp_pkg::q_wr_ctl_t              wr_ctl,
  output logic [(F+1)+4*(CW+4)-1:0]       entry
);
  import csp_pkg::*;

  localparam int unsigned TW = F + 1;
  localparam int unsigned CF = CW + 4;
  localparam int unsigned SW = ((TW > STEP_W) ? TW : STEP_W) + 1;
  localparam logic [SW-1:0] T_ONE_S = SW'(1) << F;

  logic [TW-1:0]         t_r;
  logic [TW-1:0]         t_nxt;
  logic [SW-1:0]         base;
  logic [SW-1:0]         sum;
  logic [TW-1:0]         t_use;
  logic                  accept;
  logic signed [CF-1:0]  a_x, b_x, c_x, d_x;
  logic signed [CF-1:0]  c0, c1, c2, c3;

  assign accept = in_valid && !q_full;

  always_comb begin
    base  = in_item.restart ? '0 : SW'(t_r);
    sum   = base + SW'(in_item.step_dt);
    t_nxt = (sum > T_ONE_S) ? T_ONE_S[TW-1:0] : sum[TW-1:0];
    t_use = in_item.advance ? t_nxt : t_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0;
    end else if (accept && in_item.advance) begin
      t_r <= t_nxt;
    end
  end

  // control coordinates read as CW-bit two's complement
  always_comb begin
    a_x = CF'($signed(in_item.ctrl_a[CW-1:0]));
    b_x = CF'($signed(in_item.ctrl_b[CW-1:0]));
    c_x = CF'($signed(in_item.ctrl_c[CW-1:0]));
    d_x = CF'($signed(in_item.ctrl_d[CW-1:0]));
    c0  = b_x <<< 1;
    c1  = c_x - a_x;
    c2  = (a_x <<< 1) - ((b_x <<< 2) + b_x) + (c_x <<< 2) - d_x;
    c3  = ((b_x - c_x) <<< 1) + (b_x - c_x) - a_x + d_x;
  end

  assign wr_ctl.push = accept;
  assign wr_ctl.full = q_full;
  assign entry       = {t_use, c3, c2, c1, c0};

endmodule
`default_nettype wire

// File: design/csp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module csp_queue #(
  parameter int unsigned W = 165
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire csp_pkg::q_wr_ctl_t    wr_ctl,
  input  wire logic [W-1:0]          wr_data,
  input  wire logic                  pop,
  output csp_pkg::q_rd_ctl_t         rd_ctl,
  output logic                       full,
  output logic [W-1:0]               rd_data
);
  import csp_pkg::*;

  logic [W-1:0]      slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = wr_ctl.push && !wr_ctl.full;
  assign do_pop   = pop && (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];

  assign rd_ctl.pop       = do_pop;
  assign rd_ctl.not_empty = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: design/csp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_back
// Horner evaluation of the cubic in three multiply stages, then halving,
// saturation and the output register.
// ----------------------------------------------------------------------------
module csp_back #(
  parameter int unsigned CW = 32,
  parameter int unsigned F  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire csp_pkg::q_rd_ctl_t         rd_ctl,
  input  wire logic [(F+1)+4*(CW+4)-1:0]  entry,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output csp_pkg::out_item_t              out_item
);
  import csp_pkg::*;

  localparam int unsigned TW  = F + 1;
  localparam int unsigned CF  = CW + 4;
  localparam int unsigned H1W = CW + 5;
  localparam int unsigned H2W = CW + 6;
  localparam int unsigned H3W = CW + 7;
  localparam int unsigned P1W = CF + F + 2;
  localparam int unsigned P2W = H1W + F + 2;
  localparam int unsigned P3W = H2W + F + 2;
  localparam logic signed [H3W-1:0] SAT_HI =
    {{(H3W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [H3W-1:0] SAT_LO =
    {{(H3W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic [TW-1:0]        e_t;
  logic signed [CF-1:0] e_c0, e_c1, e_c2, e_c3;

  // stage registers
  logic                  v1_r, v2_r, v3_r, vo_r;
  logic [TW-1:0]         t1_r, t2_r;
  logic signed [P1W-1:0] p1_r;
  logic signed [P2W-1:0] p2_r;
  logic signed [P3W-1:0] p3_r;
  logic signed [CF-1:0]  c2_1_r, c1_1_r, c1_2_r, c0_1_r, c0_2_r, c0_3_r;
  out_item_t             res_r, res_nxt;

  logic                  rdy1, rdy2, rdy3, rdyo;
  logic signed [TW:0]    ts0, ts1, ts2;
  logic signed [P1W-1:0] sh1;
  logic signed [P2W-1:0] sh2;
  logic signed [P3W-1:0] sh3;
  logic signed [H1W-1:0] h1;
  logic signed [H2W-1:0] h2;
  logic signed [H3W-1:0] h3, q;
  logic signed [CW-1:0]  sat_q;

  assign {e_t, e_c3, e_c2, e_c1, e_c0} = entry;

  // a stage moves when its successor is empty or moving
  assign rdyo = !vo_r || !out_stall;
  assign rdy3 = !v3_r || rdyo;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign pop  = rdy1;

  assign ts0 = $signed({1'b0, e_t});
  assign ts1 = $signed({1'b0, t1_r});
  assign ts2 = $signed({1'b0, t2_r});

  always_comb begin
    sh1 = p1_r >>> F;
    h1  = $signed(sh1[H1W-1:0]) + H1W'(c2_1_r);
    sh2 = p2_r >>> F;
    h2  = $signed(sh2[H2W-1:0]) + H2W'(c1_2_r);
    sh3 = p3_r >>> F;
    h3  = $signed(sh3[H3W-1:0]) + H3W'(c0_3_r);
    q   = h3 >>> 1;
    res_nxt.clipped = 1'b0;
    if (q > SAT_HI) begin
      sat_q           = SAT_HI[CW-1:0];
      res_nxt.clipped = 1'b1;
    end else if (q < SAT_LO) begin
      sat_q           = SAT_LO[CW-1:0];
      res_nxt.clipped = 1'b1;
    end else begin
      sat_q = q[CW-1:0];
    end
    res_nxt.point_coord = FIELD_W'(sat_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= rd_ctl.pop;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && rd_ctl.not_empty) begin
      p1_r   <= P1W'(e_c3) * P1W'(ts0);
      t1_r   <= e_t;
      c2_1_r <= e_c2;
      c1_1_r <= e_c1;
      c0_1_r <= e_c0;
    end
    if (rdy2 && v1_r) begin
      p2_r   <= P2W'(h1) * P2W'(ts1);
      t2_r   <= t1_r;
      c1_2_r <= c1_1_r;
      c0_2_r <= c0_1_r;
    end
    if (rdy3 && v2_r) begin
      p3_r   <= P3W'(h2) * P3W'(ts2);
      c0_3_r <= c0_2_r;
    end
    if (rdyo && v3_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_item  = res_r;

endmodule
`default_nettype wire

// File: design/catmull_rom_spline_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_spline_point
// Uniform Catmull-Rom segment evaluator, one axis coordinate per item.
// ----------------------------------------------------------------------------
// The block keeps a running curve parameter t (FRAC_BITS fraction bits, held
// at most 1.0) and evaluates the segment between ctrl_b and ctrl_c. An item
// with advance set first updates t (cleared by restart, plus step_dt, clamped
// at 1.0); an item with advance clear reuses t, so the axes of one point go
// as consecutive items with advance on the first. One item is taken per
// cycle while the queue is not full, limited by the add-and-clamp of t in
// the front end. The coefficients go through a four-entry queue into a
// three-multiplier Horner pipeline and the output register. in_stall
// rises only when the queue is full. Results saturate to the signed
// coordinate range and set clipped.
// ----------------------------------------------------------------------------
module catmull_rom_spline_point #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire csp_pkg::in_item_t    in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output csp_pkg::out_item_t        out_item
);
  import csp_pkg::*;

  // coordinate width above the field acts as the field width
  localparam int unsigned CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int unsigned EW = (FRAC_BITS + 1) + 4 * (CW + 4);

  q_wr_ctl_t     wr_ctl;
  q_rd_ctl_t     rd_ctl;
  logic          q_full;
  logic          pop;
  logic [EW-1:0] wr_entry;
  logic [EW-1:0] rd_entry;

  assign in_stall = q_full;

  csp_front #(
    .CW (CW),
    .F  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .wr_ctl   (wr_ctl),
    .entry    (wr_entry)
  );

  csp_queue #(
    .W (EW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_ctl  (wr_ctl),
    .wr_data (wr_entry),
    .pop     (pop),
    .rd_ctl  (rd_ctl),
    .full    (q_full),
    .rd_data (rd_entry)
  );

  csp_back #(
    .CW (CW),
    .F  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_ctl    (rd_ctl),
    .entry     (rd_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
